[rtl/modal_resonator_bank_unit_defines.svh]
// Assertion macros shared by the modal resonator bank RTL.
`ifndef MODAL_RESONATOR_BANK_UNIT_DEFINES_SVH
`define MODAL_RESONATOR_BANK_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mrb_pkg.sv]
// Shared types and constants of the modal resonator bank.
`default_nettype none

package mrb_pkg;

    // Default sizes of the bank.
    localparam int MODE_COUNT_DEF = 32;
    localparam int SINE_DEPTH_DEF = 1024;

    // Field widths.
    localparam int AMP_W     = 24;
    localparam int PHASE_W   = 32;
    localparam int DECAY_W   = 24;
    localparam int THR_W     = 23;
    localparam int SAMPLE_W  = 32;
    localparam int MODE_IDX_W = 5;

    // Stream and register port widths.
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Sine table generation constants.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMP_MAX     = 64'd8388607;

    // Reset value of the silence threshold.
    localparam logic [THR_W-1:0] THR_RESET = 23'd1;

    // Item kinds carried in s_tuser.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_SET  = 2'd2
    } opcode_t;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0
    } reg_index_t;

endpackage

`default_nettype wire

[rtl/mrb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/mrb_sine_rom.sv]
// Sine lookup table built at elaboration, with a registered read.
`default_nettype none

module mrb_sine_rom #(
    parameter int SINE_TABLE_DEPTH = mrb_pkg::SINE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(SINE_TABLE_DEPTH)
) (
    input  wire logic                             clk,
    input  wire logic [ADDR_W-1:0]                addr,
    output logic signed [mrb_pkg::AMP_W-1:0]      data
);

    import mrb_pkg::*;

    typedef logic signed [AMP_W-1:0] rom_t [SINE_TABLE_DEPTH];

    // One table entry: quarter-wave fold, then a Taylor series in Q30.
    function automatic logic signed [AMP_W-1:0] sine_entry(input logic [63:0] k);
        logic [63:0] turn;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] v;
        logic [1:0]  quad;
        logic [AMP_W-1:0] mag;
        turn = (k << 32) / SINE_TABLE_DEPTH;
        quad = turn[31:30];
        r = turn & 64'h3FFF_FFFF;
        if (quad[0])
        begin
            r = (64'd1 << 30) - r;
        end
        x = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        pos = x;
        term = (x * x2) >> 30;
        term = term / 6;
        neg = term;
        term = (term * x2) >> 30;
        term = term / 20;
        pos = pos + term;
        term = (term * x2) >> 30;
        term = term / 42;
        neg = neg + term;
        term = (term * x2) >> 30;
        term = term / 72;
        pos = pos + term;
        term = (term * x2) >> 30;
        term = term / 110;
        neg = neg + term;
        term = (term * x2) >> 30;
        term = term / 156;
        pos = pos + term;
        s = (pos > neg) ? pos - neg : 64'd0;
        v = (s * AMP_MAX + (64'd1 << 29)) >> 30;
        if (v > AMP_MAX)
        begin
            v = AMP_MAX;
        end
        mag = v[AMP_W-1:0];
        return quad[1] ? AMP_W'(0) - mag : mag;
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            t[k] = sine_entry(64'(k));
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Registered table read.
    always_ff @(posedge clk)
    begin
        data <= SINE_ROM[addr];
    end

endmodule

`default_nettype wire

[rtl/modal_resonator_bank_unit.sv]
// Top level of the modal resonator bank: control, mode pipeline and port logic.
//
//  Channel | Role            | Payload
//  --------+-----------------+-------------------------------------------------
//  s_*     | item input      | tuser: opcode; tdata: index, step, decay, amp
//  m_*     | sample output   | tdata: sample; tuser: all_silent
//  p*      | register access | silence_threshold at byte address 0
//
// During a tick the state RAMs are read once per mode, one mode per cycle; the
// multiply, table and accumulate pipeline drains and the beat is registered.
// A load is written on accept; an amplitude set reads, then writes back.
// Reset clears per-entry valid bits, so unwritten modes read as zero and no
// clearing pass is run.
// An output beat waiting on m_tready holds back only the next tick's final
// stage; while that stage waits, no items are accepted.
`default_nettype none
`include "modal_resonator_bank_unit_defines.svh"

module modal_resonator_bank_unit #(
    parameter int MODE_COUNT = mrb_pkg::MODE_COUNT_DEF,
    parameter int SINE_TABLE_DEPTH = mrb_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: mode_index [4:0], phase_increment [36:5], decay_factor [60:37],
    // amplitude_value [84:61], zero fill [87:85]
    input  wire logic [mrb_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: opcode [1:0]
    input  wire logic [mrb_pkg::S_TUSER_W-1:0] s_tuser,
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: sample [31:0]
    output logic      [mrb_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: all_silent [0]
    output logic      [mrb_pkg::M_TUSER_W-1:0] m_tuser,
    // Register port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mrb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mrb_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mrb_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    import mrb_pkg::*;

    localparam int IDX_W   = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
    localparam int TI_W    = $clog2(SINE_TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TIP_W   = PHASE_W + DEPTH_W;
    localparam int ACC_W   = (26 + $clog2(MODE_COUNT) > 33) ? 26 + $clog2(MODE_COUNT) : 33;
    localparam int WIDE_W  = IDX_W + MODE_IDX_W;
    localparam int A_W     = AMP_W + PHASE_W;
    localparam int B_W     = PHASE_W + DECAY_W;
    localparam int PROD_W  = 2 * AMP_W;

    localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(MODE_COUNT - 1);
    localparam logic signed [ACC_W-1:0]  SAT_MAX  = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0]  SAT_MIN  = ACC_W'(-64'sd2147483648);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET_WR,
        ST_TICK,
        ST_FINISH
    } state_t;

    // Control state.
    state_t                state_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  issue_reg;
    logic [MODE_COUNT-1:0] valid_a_reg;
    logic [MODE_COUNT-1:0] valid_b_reg;
    logic                  p1_v_reg;
    logic                  p2_v_reg;
    logic                  p3_v_reg;
    logic                  p4_v_reg;
    logic                  out_valid_reg;
    logic [THR_W-1:0]      thr_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                  silent_reg;

    // Payload registers.
    logic [IDX_W-1:0]      set_addr_reg;
    logic [AMP_W-1:0]      set_amp_reg;
    logic                  set_va_reg;
    logic [IDX_W-1:0]      p1_idx_reg;
    logic                  p1_va_reg;
    logic                  p1_vb_reg;
    logic [IDX_W-1:0]      p2_idx_reg;
    logic [TI_W-1:0]       p2_ti_reg;
    logic [PHASE_W-1:0]    p2_phase_reg;
    logic [PROD_W-1:0]     p2_dprod_reg;
    logic                  p2_neg_reg;
    logic signed [AMP_W-1:0] p2_amp_reg;
    logic signed [AMP_W-1:0] p3_amp_reg;
    logic signed [PROD_W-1:0] p4_prod_reg;
    logic [SAMPLE_W-1:0]   out_sample_reg;
    logic                  out_silent_reg;

    // Input field unpacking.
    logic [MODE_IDX_W-1:0] in_idx;
    logic [PHASE_W-1:0]    in_step;
    logic [DECAY_W-1:0]    in_decay;
    logic [AMP_W-1:0]      in_amp;
    logic [WIDE_W-1:0]     in_idx_wide;
    logic [IDX_W-1:0]      in_addr;
    logic                  in_range;
    logic                  s_acc;

    assign in_idx      = s_tdata[4:0];
    assign in_step     = s_tdata[36:5];
    assign in_decay    = s_tdata[60:37];
    assign in_amp      = s_tdata[84:61];
    assign in_idx_wide = {IDX_W'(0), in_idx};
    assign in_addr     = in_idx_wide[IDX_W-1:0];
    assign in_range    = in_idx_wide < WIDE_W'(MODE_COUNT);
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_acc       = s_tvalid && s_tready;

    // Memory ports.
    logic             a_wr_en;
    logic [IDX_W-1:0] a_wr_addr;
    logic [A_W-1:0]   a_wr_data;
    logic             a_rd_en;
    logic [IDX_W-1:0] a_rd_addr;
    logic [A_W-1:0]   a_rd_data;
    logic             b_wr_en;
    logic [B_W-1:0]   b_wr_data;
    logic [B_W-1:0]   b_rd_data;
    logic             set_start;
    logic             tick_start;
    logic signed [AMP_W-1:0] rom_data;

    assign set_start  = s_acc && (s_tuser == OP_SET) && in_range;
    assign tick_start = s_acc && (s_tuser == OP_TICK);

    // Stage 2 results of the mode pipeline.
    logic [AMP_W-1:0]        s2_nm;
    logic                    s2_keep;
    logic [AMP_W-1:0]        s2_new_amp;

    assign s2_nm      = p2_dprod_reg[PROD_W-1:DECAY_W];
    assign s2_keep    = s2_nm > {1'b0, thr_reg};
    assign s2_new_amp = !s2_keep ? AMP_W'(0) : (p2_neg_reg ? AMP_W'(0) - s2_nm : s2_nm);

    // RAM A holds {amplitude, phase}; written by ticks and amplitude sets.
    assign a_rd_en   = set_start || issue_reg;
    assign a_rd_addr = (state_reg == ST_IDLE) ? in_addr : cnt_reg;
    assign a_wr_en   = p2_v_reg || (state_reg == ST_SET_WR);
    assign a_wr_addr = (state_reg == ST_SET_WR) ? set_addr_reg : p2_idx_reg;
    assign a_wr_data = (state_reg == ST_SET_WR)
                     ? {set_amp_reg, (set_va_reg ? a_rd_data[PHASE_W-1:0] : PHASE_W'(0))}
                     : {s2_new_amp, p2_phase_reg};

    // RAM B holds {phase step, decay}; written by loads only.
    assign b_wr_en   = s_acc && (s_tuser == OP_LOAD) && in_range;
    assign b_wr_data = {in_step, in_decay};

    mrb_ram #(
        .WIDTH(A_W),
        .DEPTH(MODE_COUNT),
        .ADDR_W(IDX_W)
    ) u_ram_a (
        .clk    (clk),
        .wr_en  (a_wr_en),
        .wr_addr(a_wr_addr),
        .wr_data(a_wr_data),
        .rd_en  (a_rd_en),
        .rd_addr(a_rd_addr),
        .rd_data(a_rd_data)
    );

    mrb_ram #(
        .WIDTH(B_W),
        .DEPTH(MODE_COUNT),
        .ADDR_W(IDX_W)
    ) u_ram_b (
        .clk    (clk),
        .wr_en  (b_wr_en),
        .wr_addr(in_addr),
        .wr_data(b_wr_data),
        .rd_en  (issue_reg),
        .rd_addr(cnt_reg),
        .rd_data(b_rd_data)
    );

    mrb_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .ADDR_W(TI_W)
    ) u_sine_rom (
        .clk (clk),
        .addr(p2_ti_reg),
        .data(rom_data)
    );

    // Stage 1: mask unwritten entries, then table index, phase and decay product.
    logic signed [AMP_W-1:0] s1_amp;
    logic [PHASE_W-1:0]      s1_phase;
    logic [PHASE_W-1:0]      s1_step;
    logic [DECAY_W-1:0]      s1_decay;
    logic [AMP_W-1:0]        s1_mag;
    logic [TIP_W-1:0]        s1_ti_prod;

    assign s1_amp     = p1_va_reg ? a_rd_data[A_W-1:PHASE_W] : AMP_W'(0);
    assign s1_phase   = p1_va_reg ? a_rd_data[PHASE_W-1:0] : PHASE_W'(0);
    assign s1_step    = p1_vb_reg ? b_rd_data[B_W-1:DECAY_W] : PHASE_W'(0);
    assign s1_decay   = p1_vb_reg ? b_rd_data[DECAY_W-1:0] : DECAY_W'(0);
    assign s1_mag     = s1_amp[AMP_W-1] ? AMP_W'(0) - s1_amp : s1_amp;
    assign s1_ti_prod = {DEPTH_W'(0), s1_phase} * TIP_W'(SINE_TABLE_DEPTH);

    // Stage 3: amplitude times sine value.
    logic signed [PROD_W-1:0] s3_prod;

    assign s3_prod = PROD_W'(p3_amp_reg) * PROD_W'(rom_data);

    // Stage 4 contribution, floored to Q8.23.
    logic signed [PROD_W-1:0] s4_shift;

    assign s4_shift = p4_prod_reg >>> 23;

    // Saturation of the finished sum.
    logic [SAMPLE_W-1:0] sat_sample;

    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            sat_sample = 32'h7FFF_FFFF;
        end
        else if (acc_reg < SAT_MIN)
        begin
            sat_sample = 32'h8000_0000;
        end
        else
        begin
            sat_sample = acc_reg[SAMPLE_W-1:0];
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (set_start)
        begin
            set_addr_reg <= in_addr;
            set_amp_reg  <= in_amp;
            set_va_reg   <= valid_a_reg[in_addr];
        end
        p1_idx_reg   <= cnt_reg;
        p1_va_reg    <= valid_a_reg[cnt_reg];
        p1_vb_reg    <= valid_b_reg[cnt_reg];
        p2_idx_reg   <= p1_idx_reg;
        p2_ti_reg    <= s1_ti_prod[PHASE_W +: TI_W];
        p2_phase_reg <= s1_phase + s1_step;
        p2_dprod_reg <= {DECAY_W'(0), s1_mag} * {AMP_W'(0), s1_decay};
        p2_neg_reg   <= s1_amp[AMP_W-1];
        p2_amp_reg   <= s1_amp;
        p3_amp_reg   <= p2_amp_reg;
        p4_prod_reg  <= s3_prod;
    end

    // Control state machine, accumulator and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            issue_reg      <= 1'b0;
            valid_a_reg    <= '0;
            valid_b_reg    <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            p3_v_reg       <= 1'b0;
            p4_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_silent_reg <= 1'b0;
            thr_reg        <= THR_RESET;
            acc_reg        <= '0;
            silent_reg     <= 1'b1;
        end
        else
        begin
            // Register writes.
            if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD))
            begin
                thr_reg <= pwdata[THR_W-1:0];
            end

            // Pipeline valid chain.
            p1_v_reg <= issue_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;

            if (b_wr_en)
            begin
                valid_b_reg[in_addr] <= 1'b1;
            end
            if (a_wr_en)
            begin
                valid_a_reg[a_wr_addr] <= 1'b1;
            end
            if (p2_v_reg && s2_keep)
            begin
                silent_reg <= 1'b0;
            end
            if (p4_v_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(s4_shift);
            end

            // The consumer drains the output register.
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (set_start)
                    begin
                        state_reg <= ST_SET_WR;
                    end
                    else if (tick_start)
                    begin
                        state_reg  <= ST_TICK;
                        cnt_reg    <= '0;
                        issue_reg  <= 1'b1;
                        acc_reg    <= '0;
                        silent_reg <= 1'b1;
                    end
                end
                ST_SET_WR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_TICK:
                begin
                    if (issue_reg)
                    begin
                        if (cnt_reg == LAST_IDX)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + IDX_W'(1);
                        end
                    end
                    else if (!p1_v_reg && !p2_v_reg && !p3_v_reg && !p4_v_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= sat_sample;
                        out_silent_reg <= silent_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Port outputs.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_silent_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_THRESHOLD) ? {(PDATA_W - THR_W)'(0), thr_reg}
                                                  : PDATA_W'(0);

    // No item may enter while modes are still in flight.
    `MRB_ASSERT_NOW(a_busy_blocks_input, p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg, !s_tready, "item accepted while mode pipeline busy")
    // The tick write-back and the amplitude-set write-back never share a cycle.
    `MRB_ASSERT_NOW(a_ram_a_write_excl, p2_v_reg, state_reg != ST_SET_WR, "RAM A write port conflict")
    // Issue stops right after the last mode.
    `MRB_ASSERT_NEXT(a_issue_stops, issue_reg && (cnt_reg == LAST_IDX), !issue_reg, "mode issue ran past the last mode")
    // A finished tick with room in the output register shows a beat next cycle.
    `MRB_ASSERT_NEXT(a_finish_delivers, (state_reg == ST_FINISH) && (!out_valid_reg || m_tready), out_valid_reg && (state_reg == ST_IDLE), "finished tick not delivered")

endmodule

`default_nettype wire
